FILE: sv/atir_pkg.sv
// shared types and constants of the animated tile index remapper
// used by every module of the block but atir_div, no dependencies
package atir_pkg;

  localparam int unsigned NumAnims = 8;
  localparam int unsigned AnimIdxW = 3;
  localparam int unsigned AnimCntW = 4;
  localparam int unsigned TileSpace = 256;
  localparam int unsigned TileIdxW = 8;
  localparam int unsigned TileCntW = 9;

  localparam logic [2:0] ReqLoad    = 3'd0;
  localparam logic [2:0] ReqStep    = 3'd1;
  localparam logic [2:0] ReqResolve = 3'd2;
  localparam logic [2:0] ReqSig     = 3'd3;
  localparam logic [2:0] ReqRestart = 3'd4;

  localparam logic         CfgAnimCount = 1'b0;
  localparam logic         CfgTileCount = 1'b1;

  localparam logic [17:0] UsPerTick = 18'd16666;
  localparam logic [31:0] MaxWallUs = 32'd50000;
  localparam logic [3:0]  MaxTicks  = 4'd10;
  localparam logic [15:0] MaxMs     = 16'd50;
  localparam logic [15:0] UsPerMs   = 16'd1000;
  localparam logic [31:0] FnvBasis  = 32'd2166136261;
  localparam logic [31:0] FnvPrime  = 32'd16777619;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK,
    S_RB_INIT,
    S_RB_ANIM,
    S_RB_DIV1,
    S_RB_DIV2,
    S_RB_FILL,
    S_SIG_CHK,
    S_SIG_XOR,
    S_SIG_MUL,
    S_RES_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic wr_desc;
    logic accum_add;
    logic tick;
    logic clr_time;
    logic map_clear;
    logic anim_rst;
    logic anim_next;
    logic div1_start;
    logic div2_start;
    logic frame_zero;
    logic frame_take;
    logic fill_step;
    logic sig_init;
    logic sig_xor;
    logic sig_mul;
    logic sig_done;
    logic rd_tile;
    logic res_take;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       no_anims;
    logic       wall_zero;
    logic       tick_ok;
    logic       ticks_nz;
    logic       anim_done;
    logic       desc_live;
    logic       div_done;
    logic       fill_more;
    logic       base_in_range;
  } dp_stat_t;

endpackage

FILE: sv/atir_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on atir_pkg only through its callers
module atir_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic [31:0] quo_o,
  output logic [15:0] rem_o,
  output logic        done_o
);

  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q;
  logic [5:0]  bits_q, bits_d;
  logic        busy_q, busy_d;
  logic [16:0] shifted;
  logic        ge;

  assign shifted = {rem_q, quo_q[31]};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      bits_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? 16'(shifted - {1'b0, den_q}) : shifted[15:0];
      quo_d  = {quo_q[30:0], ge};
      bits_d = bits_q - 6'd1;
      busy_d = bits_q != 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bits_q <= '0;
    end else begin
      busy_q <= busy_d;
      bits_q <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = !busy_q;

endmodule

FILE: sv/atir_datapath.sv
// datapath: descriptors, tick counters, tile map memory, signature hash
// depends on atir_pkg and atir_div
module atir_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atir_pkg::dp_cmd_t    cmd_i,
  output atir_pkg::dp_stat_t   stat_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [8:0]           cfg_data_i,
  input  logic [2:0]           req_type_i,
  input  logic [2:0]           anim_slot_i,
  input  logic [7:0]           base_tile_i,
  input  logic [7:0]           frame_count_i,
  input  logic [15:0]          frame_duration_i,
  input  logic [31:0]          elapsed_us_i,
  input  logic [15:0]          delta_ms_i,
  input  logic [7:0]           tile_index_i,
  output logic [7:0]           resolved_tile_o,
  output logic [31:0]          signature_o,
  output logic [3:0]           ticks_applied_o,
  output logic [31:0]          frame_counter_now_o
);

  // latched request
  logic [2:0]  req_q;
  logic [2:0]  slot_q;
  logic [7:0]  base_q, frames_q, tile_q;
  logic [15:0] dur_q, ms_q;
  logic [31:0] us_q;

  // configuration
  logic [atir_pkg::AnimCntW-1:0] anim_cnt_q;
  logic [atir_pkg::TileCntW-1:0] tile_cnt_q;

  // descriptors
  logic [7:0]  anim_base_q   [atir_pkg::NumAnims];
  logic [7:0]  anim_frames_q [atir_pkg::NumAnims];
  logic [15:0] anim_dur_q    [atir_pkg::NumAnims];

  logic [31:0] cnt_q;
  logic [17:0] acc_q;
  logic [3:0]  ticks_q;
  logic [atir_pkg::AnimCntW-1:0] anim_q;
  logic [8:0]  fill_q;
  logic [7:0]  frame_q;
  logic [31:0] h_q, x_q, sig_q;
  logic [7:0]  res_q;

  // tile map
  logic [7:0] mem [atir_pkg::TileSpace];
  logic [atir_pkg::TileSpace-1:0] valid_q;
  logic [7:0] rd_q, rd_addr_q, rd_addr;
  logic       rd_vld_q;
  logic [7:0] map_val;

  logic [atir_pkg::AnimCntW-1:0] n_act;
  logic [atir_pkg::TileCntW-1:0] lim;
  logic [atir_pkg::AnimIdxW-1:0] ai;
  logic [7:0]  cur_base, cur_frames, shown;
  logic [15:0] cur_dur;
  logic [15:0] us_cl, ms_cl, wall;
  logic [8:0]  fill_t;
  logic        fill_wr;

  logic        div_start, div_done;
  logic [31:0] div_num, div_quo;
  logic [15:0] div_den, div_rem;

  assign n_act = (anim_cnt_q > atir_pkg::AnimCntW'(atir_pkg::NumAnims))
               ? atir_pkg::AnimCntW'(atir_pkg::NumAnims) : anim_cnt_q;
  assign lim   = (tile_cnt_q > atir_pkg::TileCntW'(atir_pkg::TileSpace))
               ? atir_pkg::TileCntW'(atir_pkg::TileSpace) : tile_cnt_q;

  assign ai         = anim_q[atir_pkg::AnimIdxW-1:0];
  assign cur_base   = anim_base_q[ai];
  assign cur_frames = anim_frames_q[ai];
  assign cur_dur    = anim_dur_q[ai];
  assign shown      = cur_base + frame_q;

  // time step clamp
  assign us_cl = (us_q > atir_pkg::MaxWallUs) ? atir_pkg::MaxWallUs[15:0] : us_q[15:0];
  assign ms_cl = (ms_q > atir_pkg::MaxMs) ? atir_pkg::MaxMs : ms_q;
  assign wall  = (us_cl != 16'd0) ? us_cl : 16'(ms_cl * atir_pkg::UsPerMs);

  assign fill_t  = {1'b0, cur_base} + fill_q;
  assign fill_wr = cmd_i.fill_step && (fill_t < lim);

  assign rd_addr = cmd_i.rd_tile ? tile_q : cur_base;
  assign map_val = rd_vld_q ? rd_q : rd_addr_q;

  // frame = (counter / duration) mod frame count, two passes of one divider
  assign div_start = cmd_i.div1_start || cmd_i.div2_start;
  assign div_num   = cmd_i.div2_start ? div_quo : cnt_q;
  assign div_den   = cmd_i.div2_start ? {8'd0, cur_frames} : cur_dur;

  atir_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (div_quo),
    .rem_o  (div_rem),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_cnt_q <= '0;
      tile_cnt_q <= atir_pkg::TileCntW'(atir_pkg::TileSpace);
      cnt_q      <= '0;
      acc_q      <= '0;
      ticks_q    <= '0;
      valid_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          atir_pkg::CfgAnimCount: anim_cnt_q <= cfg_data_i[3:0];
          atir_pkg::CfgTileCount: tile_cnt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.latch) ticks_q <= '0;
      if (cmd_i.clr_time) begin
        cnt_q <= '0;
        acc_q <= '0;
      end
      if (cmd_i.accum_add) acc_q <= acc_q + {2'd0, wall};
      if (cmd_i.tick) begin
        acc_q   <= acc_q - atir_pkg::UsPerTick;
        cnt_q   <= cnt_q + 32'd1;
        ticks_q <= ticks_q + 4'd1;
      end
      if (cmd_i.map_clear) valid_q <= '0;
      else if (fill_wr) valid_q[fill_t[7:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= req_type_i;
      slot_q   <= anim_slot_i;
      base_q   <= base_tile_i;
      frames_q <= frame_count_i;
      dur_q    <= frame_duration_i;
      us_q     <= elapsed_us_i;
      ms_q     <= delta_ms_i;
      tile_q   <= tile_index_i;
      res_q    <= '0;
      sig_q    <= '0;
    end
    if (cmd_i.wr_desc) begin
      anim_base_q[slot_q]   <= base_q;
      anim_frames_q[slot_q] <= frames_q;
      anim_dur_q[slot_q]    <= dur_q;
    end
    if (cmd_i.anim_rst || cmd_i.sig_init) anim_q <= '0;
    else if (cmd_i.anim_next) anim_q <= anim_q + atir_pkg::AnimCntW'(1);
    if (cmd_i.frame_zero) begin
      frame_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.frame_take) begin
      frame_q <= div_rem[7:0];
      fill_q  <= '0;
    end else if (cmd_i.fill_step) begin
      fill_q <= fill_q + 9'd1;
    end
    if (fill_wr) mem[fill_t[7:0]] <= shown;
    rd_q      <= mem[rd_addr];
    rd_vld_q  <= valid_q[rd_addr];
    rd_addr_q <= rd_addr;
    if (cmd_i.sig_init) h_q <= atir_pkg::FnvBasis;
    else if (cmd_i.sig_mul) h_q <= x_q * atir_pkg::FnvPrime;
    if (cmd_i.sig_xor) x_q <= h_q ^ {24'd0, map_val};
    if (cmd_i.sig_done) sig_q <= h_q;
    if (cmd_i.res_take) res_q <= ({1'b0, tile_q} < lim) ? map_val : tile_q;
  end

  always_comb begin
    stat_o.req           = req_q;
    stat_o.no_anims      = n_act == '0;
    stat_o.wall_zero     = wall == 16'd0;
    stat_o.tick_ok       = (acc_q >= atir_pkg::UsPerTick) && (ticks_q < atir_pkg::MaxTicks);
    stat_o.ticks_nz      = ticks_q != 4'd0;
    stat_o.anim_done     = anim_q >= n_act;
    stat_o.desc_live     = (cur_dur != 16'd0) && (cur_frames != 8'd0);
    stat_o.div_done      = div_done;
    stat_o.fill_more     = fill_q < {1'b0, cur_frames};
    stat_o.base_in_range = {1'b0, cur_base} < lim;
  end

  assign resolved_tile_o     = res_q;
  assign signature_o         = sig_q;
  assign ticks_applied_o     = ticks_q;
  assign frame_counter_now_o = cnt_q;

endmodule

FILE: sv/atir_ctrl.sv
// control state machine sequencing each request through the datapath
// depends on atir_pkg
module atir_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  atir_pkg::dp_stat_t stat_i,
  output atir_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  atir_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= atir_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      atir_pkg::S_IDLE: if (start_i) state_d = atir_pkg::S_DISPATCH;
      atir_pkg::S_DISPATCH: begin
        priority if (stat_i.req == atir_pkg::ReqLoad || stat_i.req == atir_pkg::ReqRestart)
          state_d = atir_pkg::S_RB_INIT;
        else if (stat_i.req == atir_pkg::ReqStep)
          state_d = (stat_i.no_anims || stat_i.wall_zero) ? atir_pkg::S_DONE
                                                          : atir_pkg::S_TICK;
        else if (stat_i.req == atir_pkg::ReqResolve) state_d = atir_pkg::S_RES_WAIT;
        else if (stat_i.req == atir_pkg::ReqSig)     state_d = atir_pkg::S_SIG_CHK;
        else                                         state_d = atir_pkg::S_DONE;
      end
      atir_pkg::S_TICK: begin
        priority if (stat_i.tick_ok) state_d = atir_pkg::S_TICK;
        else if (stat_i.ticks_nz)    state_d = atir_pkg::S_RB_INIT;
        else                         state_d = atir_pkg::S_DONE;
      end
      atir_pkg::S_RB_INIT: state_d = atir_pkg::S_RB_ANIM;
      atir_pkg::S_RB_ANIM: begin
        priority if (stat_i.anim_done) state_d = atir_pkg::S_DONE;
        else if (stat_i.desc_live)     state_d = atir_pkg::S_RB_DIV1;
        else                           state_d = atir_pkg::S_RB_FILL;
      end
      atir_pkg::S_RB_DIV1: if (stat_i.div_done) state_d = atir_pkg::S_RB_DIV2;
      atir_pkg::S_RB_DIV2: if (stat_i.div_done) state_d = atir_pkg::S_RB_FILL;
      atir_pkg::S_RB_FILL: if (!stat_i.fill_more) state_d = atir_pkg::S_RB_ANIM;
      atir_pkg::S_SIG_CHK: begin
        priority if (stat_i.anim_done) state_d = atir_pkg::S_DONE;
        else if (stat_i.base_in_range) state_d = atir_pkg::S_SIG_XOR;
        else                           state_d = atir_pkg::S_SIG_CHK;
      end
      atir_pkg::S_SIG_XOR:  state_d = atir_pkg::S_SIG_MUL;
      atir_pkg::S_SIG_MUL:  state_d = atir_pkg::S_SIG_CHK;
      atir_pkg::S_RES_WAIT: state_d = atir_pkg::S_DONE;
      atir_pkg::S_DONE:     state_d = atir_pkg::S_IDLE;
      default:              state_d = atir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = state_q != atir_pkg::S_IDLE;
    done_o = state_q == atir_pkg::S_DONE;
    unique case (state_q)
      atir_pkg::S_IDLE: cmd_o.latch = start_i;
      atir_pkg::S_DISPATCH: begin
        cmd_o.wr_desc   = stat_i.req == atir_pkg::ReqLoad;
        cmd_o.clr_time  = stat_i.req == atir_pkg::ReqRestart;
        cmd_o.accum_add = (stat_i.req == atir_pkg::ReqStep)
                          && !stat_i.no_anims && !stat_i.wall_zero;
        cmd_o.rd_tile   = stat_i.req == atir_pkg::ReqResolve;
        cmd_o.sig_init  = stat_i.req == atir_pkg::ReqSig;
      end
      atir_pkg::S_TICK: cmd_o.tick = stat_i.tick_ok;
      atir_pkg::S_RB_INIT: begin
        cmd_o.map_clear = 1'b1;
        cmd_o.anim_rst  = 1'b1;
      end
      atir_pkg::S_RB_ANIM: begin
        cmd_o.div1_start = !stat_i.anim_done && stat_i.desc_live;
        cmd_o.frame_zero = !stat_i.anim_done && !stat_i.desc_live;
      end
      atir_pkg::S_RB_DIV1: cmd_o.div2_start = stat_i.div_done;
      atir_pkg::S_RB_DIV2: cmd_o.frame_take = stat_i.div_done;
      atir_pkg::S_RB_FILL: begin
        cmd_o.fill_step = stat_i.fill_more;
        cmd_o.anim_next = !stat_i.fill_more;
      end
      atir_pkg::S_SIG_CHK: begin
        cmd_o.sig_done  = stat_i.anim_done;
        cmd_o.anim_next = !stat_i.anim_done && !stat_i.base_in_range;
      end
      atir_pkg::S_SIG_XOR: cmd_o.sig_xor = 1'b1;
      atir_pkg::S_SIG_MUL: begin
        cmd_o.sig_mul   = 1'b1;
        cmd_o.anim_next = 1'b1;
      end
      atir_pkg::S_RES_WAIT: cmd_o.res_take = 1'b1;
      atir_pkg::S_DONE: ;
      default: ;
    endcase
  end

endmodule

FILE: sv/animated_tile_index_remap.sv
// top level of the animated tile index remapper
// depends on atir_pkg, atir_ctrl, atir_datapath (and atir_div below it)
//
// usage
//   a request is taken at a clock edge with start high and busy low; its
//   fields are sampled at that edge. done_o marks one result per request,
//   high for a single cycle, which the receiver cannot stall; busy stays high
//   until that cycle is over, and the result ports hold until the next request.
//   configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 anim_count, 1 tile_count) at once. the user is bound to write only
//   while the block is idle; the block itself has no check for it.
// sequence, from the accept edge to the done_o cycle; requests never overlap
//   resolve: map read, then result capture; unknown request: straight to done
//   signature: map read, xor and multiply per active animation whose base
//   tile is in range, a single check per active animation out of range
//   time step: accumulate, take ticks (up to 10), rebuild if any was taken
//   load and restart: a rebuild, walking each active animation: two divider
//   passes when it moves, then one map write per frame of its tile range
// reset
//   clears time, configuration to anim_count 0 and tile_count 256, and the
//   map to identity through per-entry valid bits; descriptors hold junk
module animated_tile_index_remap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic [2:0]  req_type_i,
  input  logic [2:0]  anim_slot_i,
  input  logic [7:0]  base_tile_i,
  input  logic [7:0]  frame_count_i,
  input  logic [15:0] frame_duration_i,
  input  logic [31:0] elapsed_us_i,
  input  logic [15:0] delta_ms_i,
  input  logic [7:0]  tile_index_i,
  output logic [7:0]  resolved_tile_o,
  output logic [31:0] signature_o,
  output logic [3:0]  ticks_applied_o,
  output logic [31:0] frame_counter_now_o
);

  // command and status between sequencer and datapath
  atir_pkg::dp_cmd_t  cmd;
  atir_pkg::dp_stat_t stat;

  atir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  atir_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .req_type_i         (req_type_i),
    .anim_slot_i        (anim_slot_i),
    .base_tile_i        (base_tile_i),
    .frame_count_i      (frame_count_i),
    .frame_duration_i   (frame_duration_i),
    .elapsed_us_i       (elapsed_us_i),
    .delta_ms_i         (delta_ms_i),
    .tile_index_i       (tile_index_i),
    .resolved_tile_o    (resolved_tile_o),
    .signature_o        (signature_o),
    .ticks_applied_o    (ticks_applied_o),
    .frame_counter_now_o(frame_counter_now_o)
  );

endmodule
